// ===== src/edt_pkg.sv =====
// Shared types and constants for the edge dedup / degree tracker.
// No dependencies; the other files in src apart from edt_ram use it by scoped name.
package edt_pkg;

  localparam int NODES   = 256;
  localparam int IDX_W   = (NODES > 1) ? $clog2(NODES) : 1;
  localparam int NODE_W  = 8;
  localparam int CNT_W   = 9;

  localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

  typedef struct packed {
    logic [NODE_W-1:0] src_node;
    logic [NODE_W-1:0] dst_node;
  } in_item_t;

  typedef struct packed {
    logic              duplicate;
    logic [CNT_W-1:0]  src_out_degree;
    logic [CNT_W-1:0]  dst_in_degree;
    logic [CNT_W-1:0]  max_out_degree;
    logic [NODE_W-1:0] max_out_node;
    logic [CNT_W-1:0]  max_in_degree;
    logic [NODE_W-1:0] max_in_node;
  } out_item_t;

  // Candidate offered to a running-maximum tracker.
  typedef struct packed {
    logic              upd;
    logic [CNT_W-1:0]  cnt;
    logic [NODE_W-1:0] node;
  } cand_t;

endpackage

// ===== src/edt_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module edt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== src/edt_max_track.sv =====
// Running maximum with lowest-index tie break for one degree table.
// Depends on edt_pkg.
module edt_max_track (
  input  logic                      clk,
  input  logic                      rst_n,
  input  edt_pkg::cand_t            cand,
  output logic [edt_pkg::CNT_W-1:0]  best_cnt,
  output logic [edt_pkg::NODE_W-1:0] best_node
);

  logic [edt_pkg::CNT_W-1:0]  best_cnt_r,  best_cnt_nxt;
  logic [edt_pkg::NODE_W-1:0] best_node_r, best_node_nxt;

  always_comb begin
    best_cnt_nxt  = best_cnt_r;
    best_node_nxt = best_node_r;
    if (cand.upd) begin
      if (cand.cnt > best_cnt_r) begin
        best_cnt_nxt  = cand.cnt;
        best_node_nxt = cand.node;
      end else if (cand.cnt == best_cnt_r && cand.node < best_node_r) begin
        best_node_nxt = cand.node;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_cnt_r  <= '0;
      best_node_r <= '0;
    end else begin
      best_cnt_r  <= best_cnt_nxt;
      best_node_r <= best_node_nxt;
    end
  end

  // Expose the post-update value so the result shows this item's effect.
  assign best_cnt  = best_cnt_nxt;
  assign best_node = best_node_nxt;

endmodule

// ===== src/edge_dedup_degree_tracker.sv =====
// Edge dedup / degree tracker top level: bitmap and degree RAMs, max trackers.
// Depends on edt_pkg, edt_ram and edt_max_track.
// Item and RAM reads are registered on accept; the result register loads when
// the item finishes, once the output is free or draining. Input stalls while an
// item is in flight, through the read-modify-write of the bitmap row and degree entries.
// Reset: a clearing pass over all NODES rows zeroes the RAMs; input stalled.
module edge_dedup_degree_tracker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  edt_pkg::in_item_t   in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output edt_pkg::out_item_t  out_item
);

  localparam int IDX_W = edt_pkg::IDX_W;
  localparam int CNT_W = edt_pkg::CNT_W;

  // Clearing pass state
  logic             clearing_r, clearing_nxt;
  logic [IDX_W-1:0] clr_addr_r, clr_addr_nxt;

  // Item in flight between read and write back
  logic              busy_r, busy_nxt;
  edt_pkg::in_item_t item_r, item_nxt;

  // Result register
  logic               out_valid_r, out_valid_nxt;
  edt_pkg::out_item_t out_item_r, out_item_nxt;

  logic accept;
  logic fin;
  logic in_range;
  logic dup;
  logic commit;

  logic [IDX_W-1:0] src_idx, dst_idx;
  logic [IDX_W-1:0] rd_src_idx, rd_dst_idx;

  logic [edt_pkg::NODES-1:0] row_rd, row_wr, row_wdata;
  logic [CNT_W-1:0]          out_cnt_rd, in_cnt_rd;
  logic [CNT_W-1:0]          out_cnt_new, in_cnt_new;
  logic [CNT_W-1:0]          out_cnt_wdata, in_cnt_wdata;
  logic [IDX_W-1:0]          out_waddr, in_waddr, row_waddr;
  logic                      mem_we;

  edt_pkg::cand_t                out_cand, in_cand;
  logic [CNT_W-1:0]              best_out_cnt, best_in_cnt;
  logic [edt_pkg::NODE_W-1:0]    best_out_node, best_in_node;

  // Handshake: take an item only when the RAMs are cleared and nothing is in
  // flight; the result register parts us from the output side.
  assign in_stall = clearing_r | busy_r;
  assign accept   = in_valid & ~in_stall;
  // Finish the item in flight once the result register is free or draining.
  assign fin      = busy_r & (~out_valid_r | ~out_stall);

  assign rd_src_idx = IDX_W'(in_item.src_node);
  assign rd_dst_idx = IDX_W'(in_item.dst_node);
  assign src_idx    = IDX_W'(item_r.src_node);
  assign dst_idx    = IDX_W'(item_r.dst_node);

  // Drop any edge whose nodes lie beyond the table.
  assign in_range = (32'(item_r.src_node) < 32'(edt_pkg::NODES)) &&
                    (32'(item_r.dst_node) < 32'(edt_pkg::NODES));

  assign dup    = row_rd[dst_idx];
  assign commit = fin & in_range & ~dup;

  // Saturating increments
  assign out_cnt_new = (out_cnt_rd != edt_pkg::COUNT_MAX) ? out_cnt_rd + CNT_W'(1) : out_cnt_rd;
  assign in_cnt_new  = (in_cnt_rd  != edt_pkg::COUNT_MAX) ? in_cnt_rd  + CNT_W'(1) : in_cnt_rd;

  always_comb begin
    row_wr          = row_rd;
    row_wr[dst_idx] = 1'b1;
  end

  // Write port: clearing pass first, otherwise the committed edge.
  assign mem_we        = clearing_r | commit;
  assign row_waddr     = clearing_r ? clr_addr_r : src_idx;
  assign out_waddr     = clearing_r ? clr_addr_r : src_idx;
  assign in_waddr      = clearing_r ? clr_addr_r : dst_idx;
  assign row_wdata     = clearing_r ? '0 : row_wr;
  assign out_cnt_wdata = clearing_r ? '0 : out_cnt_new;
  assign in_cnt_wdata  = clearing_r ? '0 : in_cnt_new;

  edt_ram #(.WIDTH(edt_pkg::NODES), .DEPTH(edt_pkg::NODES)) u_bitmap (
    .clk   (clk),
    .we    (mem_we),
    .waddr (row_waddr),
    .wdata (row_wdata),
    .re    (accept),
    .raddr (rd_src_idx),
    .rdata (row_rd)
  );

  edt_ram #(.WIDTH(CNT_W), .DEPTH(edt_pkg::NODES)) u_out_cnt (
    .clk   (clk),
    .we    (mem_we),
    .waddr (out_waddr),
    .wdata (out_cnt_wdata),
    .re    (accept),
    .raddr (rd_src_idx),
    .rdata (out_cnt_rd)
  );

  edt_ram #(.WIDTH(CNT_W), .DEPTH(edt_pkg::NODES)) u_in_cnt (
    .clk   (clk),
    .we    (mem_we),
    .waddr (in_waddr),
    .wdata (in_cnt_wdata),
    .re    (accept),
    .raddr (rd_dst_idx),
    .rdata (in_cnt_rd)
  );

  // Offer the new degrees to the running maxima only for a fresh edge.
  assign out_cand = '{upd: commit, cnt: out_cnt_new, node: item_r.src_node};
  assign in_cand  = '{upd: commit, cnt: in_cnt_new,  node: item_r.dst_node};

  edt_max_track u_max_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .cand      (out_cand),
    .best_cnt  (best_out_cnt),
    .best_node (best_out_node)
  );

  edt_max_track u_max_in (
    .clk       (clk),
    .rst_n     (rst_n),
    .cand      (in_cand),
    .best_cnt  (best_in_cnt),
    .best_node (best_in_node)
  );

  always_comb begin
    clearing_nxt = clearing_r;
    clr_addr_nxt = clr_addr_r;
    if (clearing_r) begin
      // Advance through every row, then release the input.
      if (clr_addr_r == IDX_W'(edt_pkg::NODES - 1)) begin
        clearing_nxt = 1'b0;
      end else begin
        clr_addr_nxt = clr_addr_r + IDX_W'(1);
      end
    end
  end

  always_comb begin
    busy_nxt = busy_r;
    item_nxt = item_r;
    if (accept) begin
      busy_nxt = 1'b1;
      item_nxt = in_item;
    end else if (fin) begin
      busy_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r & out_stall;
    out_item_nxt  = out_item_r;
    if (fin) begin
      out_valid_nxt               = 1'b1;
      out_item_nxt.duplicate      = in_range & dup;
      out_item_nxt.src_out_degree = !in_range ? '0 : (dup ? out_cnt_rd : out_cnt_new);
      out_item_nxt.dst_in_degree  = !in_range ? '0 : (dup ? in_cnt_rd  : in_cnt_new);
      out_item_nxt.max_out_degree = best_out_cnt;
      out_item_nxt.max_out_node   = best_out_node;
      out_item_nxt.max_in_degree  = best_in_cnt;
      out_item_nxt.max_in_node    = best_in_node;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r  <= 1'b1;
      clr_addr_r  <= '0;
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      clearing_r  <= clearing_nxt;
      clr_addr_r  <= clr_addr_nxt;
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers hold without reset.
  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

// ===== verif/edge_dedup_degree_tracker_tb.sv =====
// Self-checking testbench for edge_dedup_degree_tracker: directed, hub and random edges.
// Depends on edt_pkg and the RTL in src; it keeps its own degree table to predict each result.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NODES  = edt_pkg::NODES;
  localparam int CNT_W  = edt_pkg::CNT_W;
  localparam int NODE_W = edt_pkg::NODE_W;

  // The slowest correct run is about 900 items plus the clearing pass and the long
  // hold-off; allow many times that.
  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 150;

  typedef struct packed {
    logic [CNT_W-1:0]  cnt;
    logic [NODE_W-1:0] node;
  } leader_t;

  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  logic               in_stall;
  edt_pkg::in_item_t  in_item   = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  edt_pkg::out_item_t out_item;

  // Degree table kept alongside the block.
  bit               edge_seen [0:NODES*NODES-1];
  logic [CNT_W-1:0] out_deg   [0:NODES-1];
  logic [CNT_W-1:0] in_deg    [0:NODES-1];
  leader_t          out_leader;
  leader_t          in_leader;

  edt_pkg::out_item_t expected_q [$];
  edt_pkg::in_item_t  sent_edges [$];

  int mismatches  = 0;
  int cycle_count = 0;
  bit idle_on     = 1'b0;
  bit hold_req    = 1'b0;
  bit hold_ack    = 1'b0;
  int hold_left   = 0;
  int stall_left  = 0;

  always #10 clk = ~clk;

  edge_dedup_degree_tracker u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  function automatic logic [NODE_W-1:0] rand_node();
    return NODE_W'($urandom_range(0, NODES - 1));
  endfunction

  // Raise the holder when the count beats the maximum; on a tie keep the lower index.
  function automatic leader_t bump_leader(leader_t cur, logic [CNT_W-1:0] cnt,
                                          logic [NODE_W-1:0] node);
    leader_t nxt;
    nxt = cur;
    if (cnt > cur.cnt) begin
      nxt.cnt  = cnt;
      nxt.node = node;
    end else if (cnt == cur.cnt && node < cur.node) begin
      nxt.node = node;
    end
    return nxt;
  endfunction

  // Apply one edge to the degree table and return the result the block should give.
  function automatic edt_pkg::out_item_t predict_degrees(edt_pkg::in_item_t e);
    edt_pkg::out_item_t r;
    int                 pair;
    r = '0;
    // Out-of-range nodes leave everything untouched and report zero degrees.
    if (int'(e.src_node) < NODES && int'(e.dst_node) < NODES) begin
      pair = int'(e.src_node) * NODES + int'(e.dst_node);
      if (edge_seen[pair]) begin
        // Repeated edge: flag it and change nothing.
        r.duplicate = 1'b1;
      end else begin
        edge_seen[pair] = 1'b1;
        if (out_deg[e.src_node] != edt_pkg::COUNT_MAX)
          out_deg[e.src_node] = out_deg[e.src_node] + CNT_W'(1);
        if (in_deg[e.dst_node] != edt_pkg::COUNT_MAX)
          in_deg[e.dst_node] = in_deg[e.dst_node] + CNT_W'(1);
        out_leader = bump_leader(out_leader, out_deg[e.src_node], e.src_node);
        in_leader  = bump_leader(in_leader, in_deg[e.dst_node], e.dst_node);
      end
      r.src_out_degree = out_deg[e.src_node];
      r.dst_in_degree  = in_deg[e.dst_node];
    end
    r.max_out_degree = out_leader.cnt;
    r.max_out_node   = out_leader.node;
    r.max_in_degree  = in_leader.cnt;
    r.max_in_node    = in_leader.node;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [CNT_W-1:0] got,
                                 input logic [CNT_W-1:0] want);
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    mismatches++;
  endtask

  // Offer one edge, optionally after an idle burst, and hold it until accepted.
  // Leaves in_valid high so the next item can follow back to back.
  task automatic send_edge(input logic [NODE_W-1:0] src, input logic [NODE_W-1:0] dst);
    edt_pkg::in_item_t e;
    e.src_node = src;
    e.dst_node = dst;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_item  <= e;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    expected_q.insert(expected_q.size(), predict_degrees(e));
    sent_edges.insert(sent_edges.size(), e);
  endtask

  // Drop valid and wait for every outstanding result to come back.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
  endtask

  // Extremes of both fields, self-loops, duplicates and ties to the lower index.
  task automatic test_directed_edges();
    send_edge(8'd0, 8'd0);       // self-loop on the lowest node
    send_edge(8'd0, 8'd0);       // same edge again: duplicate
    send_edge(8'd255, 8'd255);   // self-loop on the highest node, ties stay with node 0
    send_edge(8'd255, 8'd0);     // node 255 takes the out maximum alone
    send_edge(8'd0, 8'd255);     // node 0 rises to equal it and wins the tie
    send_edge(8'd255, 8'd0);     // duplicate
    send_edge(8'd170, 8'd85);
    send_edge(8'd85, 8'd170);
    send_edge(8'd128, 8'd127);
    send_edge(8'd127, 8'd128);
    send_edge(8'd1, 8'd254);
    send_edge(8'd254, 8'd1);
    send_edge(8'd127, 8'd128);   // duplicate
    send_edge(8'd170, 8'd85);    // duplicate
    send_edge(8'd85, 8'd85);     // self-loop mid-range
    send_edge(8'd254, 8'd254);
    send_edge(8'd1, 8'd1);
    send_edge(8'd255, 8'd254);
    send_edge(8'd0, 8'd254);
    send_edge(8'd255, 8'd255);   // duplicate self-loop
  endtask

  // Hold the receiver off for a long stretch while edges keep coming, so the
  // block fills up and stalls its input.
  task automatic test_receiver_hold();
    hold_req <= ~hold_req;
    repeat (40) send_edge(rand_node(), rand_node());
    wait_drained();
  endtask

  // Connect a hub to every node in shuffled order.
  task automatic fan_edges(input logic [NODE_W-1:0] hub, input bit hub_is_src);
    int order [0:NODES-1];
    int j;
    int t;
    for (int i = 0; i < NODES; i++) order[i] = i;
    for (int i = NODES - 1; i > 0; i--) begin
      j        = int'($urandom_range(0, i));
      t        = order[i];
      order[i] = order[j];
      order[j] = t;
    end
    for (int i = 0; i < NODES; i++) begin
      if (hub_is_src) begin
        send_edge(hub, NODE_W'(order[i]));
      end else begin
        send_edge(NODE_W'(order[i]), hub);
      end
    end
  endtask

  // Drive one out-degree and one in-degree to their full value of NODES.
  task automatic test_hub_degrees();
    fan_edges(rand_node(), 1'b1);
    fan_edges(rand_node(), 1'b0);
  endtask

  // Mostly edges within a small node set, so degrees climb and ties and
  // duplicates are frequent; the rest are replays of earlier edges and noise.
  task automatic test_random_mix(input int count, input bit idling);
    logic [NODE_W-1:0] pool [0:11];
    edt_pkg::in_item_t e;
    int                pick;
    idle_on <= idling;
    for (int i = 0; i < 12; i++) pool[i] = rand_node();
    for (int n = 0; n < count; n++) begin
      pick = int'($urandom_range(0, 9));
      if (pick < 6) begin
        send_edge(pool[$urandom_range(0, 11)], pool[$urandom_range(0, 11)]);
      end else if (pick < 8) begin
        e = sent_edges[$urandom_range(0, sent_edges.size() - 1)];
        send_edge(e.src_node, e.dst_node);
      end else begin
        send_edge(rand_node(), rand_node());
      end
    end
  endtask

  // Receiver side: a long hold when asked, otherwise random stall bursts.
  always @(posedge clk) begin : receiver_side
    if (hold_req != hold_ack) begin
      hold_ack  <= hold_req;
      out_stall <= 1'b1;
      hold_left <= HOLD_CYCLES - 1;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (stall_left > 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      out_stall  <= 1'b1;
      stall_left <= int'($urandom_range(0, 6));
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Compare every accepted result with the oldest prediction, field by field.
  always @(posedge clk) begin : result_check
    edt_pkg::out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_q.size() == 0) begin
        report_mismatch("result with nothing outstanding", CNT_W'(1), CNT_W'(0));
      end else begin
        want = expected_q.pop_front();
        if (out_item.duplicate !== want.duplicate)
          report_mismatch("duplicate", CNT_W'(out_item.duplicate), CNT_W'(want.duplicate));
        if (out_item.src_out_degree !== want.src_out_degree)
          report_mismatch("src_out_degree", out_item.src_out_degree, want.src_out_degree);
        if (out_item.dst_in_degree !== want.dst_in_degree)
          report_mismatch("dst_in_degree", out_item.dst_in_degree, want.dst_in_degree);
        if (out_item.max_out_degree !== want.max_out_degree)
          report_mismatch("max_out_degree", out_item.max_out_degree, want.max_out_degree);
        if (out_item.max_out_node !== want.max_out_node)
          report_mismatch("max_out_node", CNT_W'(out_item.max_out_node),
                          CNT_W'(want.max_out_node));
        if (out_item.max_in_degree !== want.max_in_degree)
          report_mismatch("max_in_degree", out_item.max_in_degree, want.max_in_degree);
        if (out_item.max_in_node !== want.max_in_node)
          report_mismatch("max_in_node", CNT_W'(out_item.max_in_node),
                          CNT_W'(want.max_in_node));
      end
    end
  end

  // Watchdog: end the run if it hangs.
  always @(posedge clk) begin : watchdog
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < NODES; i++) begin
      out_deg[i] = '0;
      in_deg[i]  = '0;
    end
    out_leader = '0;
    in_leader  = '0;

    // Hold reset; the clearing pass that follows shows as in_stall.
    repeat (12) @(posedge clk);
    rst_n   <= 1'b1;
    idle_on <= 1'b1;

    test_directed_edges();
    // Pause the sender until everything has come back.
    wait_drained();
    test_receiver_hold();
    test_hub_degrees();
    test_random_mix(100, 1'b1);
    test_random_mix(40, 1'b0);
    test_random_mix(80, 1'b1);
    // Last stretch runs flat out on both sides.
    test_random_mix(80, 1'b0);

    wait_drained();
    // Let any stray result surface before judging.
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
